// File: design/pdc_pkg.sv
// ============================================================================
// pdc_pkg
// Shared constants, codes and control structs for the point dedup collector.
// ============================================================================
package pdc_pkg;

    // Default sizing of the point table and the coordinate width.
    localparam int MAX_POINTS_DEF = 30;
    localparam int COORD_BITS_DEF = 16;

    // Fixed widths of the channel and register fields.
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 16;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int RANGE_W  = 8;

    // Function codes of an input beat.
    localparam logic [FUNC_W-1:0] FUNC_CAND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NO_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_CLOSE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL_END  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd7;

    // Configuration registers: index, reset value and bus width.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_RANGE_MIN     = 1'b0;
    localparam logic REG_EXIT_ON_FIRST = 1'b1;
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST = 8'd50;
    localparam logic EXIT_ON_FIRST_RST = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_item;
        logic                scan_clr;
        logic                scan_rd;
        logic                idx_rd;
        logic                finish;
        logic [STATUS_W-1:0] status;
        logic                store;
        logic                set_done;
        logic                clear;
    } pdc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              hit;
        logic              done;
        logic              full;
        logic              empty;
        logic              idx_ok;
        logic              scan_last;
        logic              near;
        logic              out_free;
    } pdc_stat_t;

endpackage

// File: design/pdc_item_if.sv
// ============================================================================
// pdc_item_if
// Input channel of the point dedup collector: one request beat.
// ============================================================================
interface pdc_item_if;
    logic                            valid;
    logic                            ready;
    logic [pdc_pkg::FUNC_W-1:0]      func;
    logic [pdc_pkg::POS_W-1:0]       pos_x;
    logic [pdc_pkg::POS_W-1:0]       pos_y;
    logic                            hit;
    logic [pdc_pkg::INDEX_W-1:0]     entry_index;

    modport source (output valid, func, pos_x, pos_y, hit, entry_index, input ready);
    modport sink   (input valid, func, pos_x, pos_y, hit, entry_index, output ready);
endinterface

// File: design/pdc_result_if.sv
// ============================================================================
// pdc_result_if
// Output channel of the point dedup collector: one result beat.
// ============================================================================
interface pdc_result_if;
    logic                            valid;
    logic                            ready;
    logic [pdc_pkg::STATUS_W-1:0]    status;
    logic [pdc_pkg::COUNT_W-1:0]     point_count;
    logic [pdc_pkg::POS_W-1:0]       read_x;
    logic [pdc_pkg::POS_W-1:0]       read_y;
    logic                            finished;

    modport source (output valid, status, point_count, read_x, read_y, finished, input ready);
    modport sink   (input valid, status, point_count, read_x, read_y, finished, output ready);
endinterface

// File: design/pdc_ctrl.sv
// ============================================================================
// pdc_ctrl
// Controller state machine: decodes the captured beat, sequences the table
// scan and the entry reads, and issues the finishing command.
// ============================================================================
module pdc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                exit_on_first,
    input  pdc_pkg::pdc_stat_t  st,
    output pdc_pkg::pdc_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       want_fin;
    logic [pdc_pkg::STATUS_W-1:0] fin_status;
    logic       fin_store;
    logic       fin_set_done;
    logic       fin_clear;

    assign item_ready = (state_reg == S_IDLE);

    // Next state and the wanted finishing action.
    always_comb
    begin
        state_next   = state_reg;
        want_fin     = 1'b0;
        fin_status   = pdc_pkg::ST_IGNORED;
        fin_store    = 1'b0;
        fin_set_done = 1'b0;
        fin_clear    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = item_valid;
                if (item_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (st.func)
                    pdc_pkg::FUNC_CAND:
                    begin
                        if (st.done)
                        begin
                            want_fin   = 1'b1;
                            fin_status = pdc_pkg::ST_IGNORED;
                        end
                        else if (!st.hit)
                        begin
                            want_fin   = 1'b1;
                            fin_status = pdc_pkg::ST_NO_HIT;
                        end
                        else if (st.full)
                        begin
                            want_fin     = 1'b1;
                            fin_status   = pdc_pkg::ST_FULL_END;
                            fin_set_done = 1'b1;
                        end
                        else if (st.empty)
                        begin
                            // Nothing stored yet, so nothing can be too close.
                            want_fin     = 1'b1;
                            fin_status   = pdc_pkg::ST_STORED;
                            fin_store    = 1'b1;
                            fin_set_done = exit_on_first;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    pdc_pkg::FUNC_READ:
                    begin
                        if (st.idx_ok)
                        begin
                            cmd.idx_rd = 1'b1;
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            want_fin   = 1'b1;
                            fin_status = pdc_pkg::ST_BAD_INDEX;
                        end
                    end
                    pdc_pkg::FUNC_CLEAR:
                    begin
                        want_fin   = 1'b1;
                        fin_status = pdc_pkg::ST_CLEARED;
                        fin_clear  = 1'b1;
                    end
                    default:
                    begin
                        want_fin   = 1'b1;
                        fin_status = pdc_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                want_fin     = 1'b1;
                fin_status   = st.near ? pdc_pkg::ST_TOO_CLOSE : pdc_pkg::ST_STORED;
                fin_store    = !st.near;
                fin_set_done = !st.near && exit_on_first;
            end
            S_RDWAIT:
            begin
                want_fin   = 1'b1;
                fin_status = pdc_pkg::ST_READ_OK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A result is only issued once the output register is free.
        if (want_fin && st.out_free)
        begin
            cmd.finish   = 1'b1;
            cmd.status   = fin_status;
            cmd.store    = fin_store;
            cmd.set_done = fin_set_done;
            cmd.clear    = fin_clear;
            state_next   = S_IDLE;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/pdc_dp.sv
// ============================================================================
// pdc_dp
// Datapath: captured beat, point memory with registered read, distance
// compare, point count and done flag, and the result register.
// ============================================================================
module pdc_dp
#(
    parameter int MAX_POINTS = pdc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [pdc_pkg::RANGE_W-1:0]     range_min,
    input  pdc_pkg::pdc_cmd_t               cmd,
    output pdc_pkg::pdc_stat_t              st,
    input  logic [pdc_pkg::FUNC_W-1:0]      func,
    input  logic [pdc_pkg::POS_W-1:0]       pos_x,
    input  logic [pdc_pkg::POS_W-1:0]       pos_y,
    input  logic                            hit,
    input  logic [pdc_pkg::INDEX_W-1:0]     entry_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pdc_pkg::STATUS_W-1:0]    out_status,
    output logic [pdc_pkg::COUNT_W-1:0]     out_point_count,
    output logic [pdc_pkg::POS_W-1:0]       out_read_x,
    output logic [pdc_pkg::POS_W-1:0]       out_read_y,
    output logic                            out_finished
);

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CMP_W   = (CNT_W > pdc_pkg::INDEX_W) ? CNT_W : pdc_pkg::INDEX_W;
    localparam int ENTRY_W = 2 * COORD_BITS;

    // Captured beat.
    logic [pdc_pkg::FUNC_W-1:0] func_reg;
    logic [COORD_BITS-1:0]      x_reg;
    logic [COORD_BITS-1:0]      y_reg;
    logic                       hit_reg;
    logic [CMP_W-1:0]           idx_reg;

    // Table state.
    logic [ENTRY_W-1:0] pt_mem [MAX_POINTS];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               done_next;

    // Scan and read path.
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic               near_reg;
    logic               near_now;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] rng;

    // Result register.
    logic                            out_valid_reg;
    logic [pdc_pkg::STATUS_W-1:0]    status_reg;
    logic [pdc_pkg::COUNT_W-1:0]     pcount_reg;
    logic [pdc_pkg::POS_W-1:0]       read_x_reg;
    logic [pdc_pkg::POS_W-1:0]       read_y_reg;
    logic                            finished_reg;

    // Capture the accepted beat; coordinates keep only the stored width.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= func;
            x_reg    <= pos_x[COORD_BITS-1:0];
            y_reg    <= pos_y[COORD_BITS-1:0];
            hit_reg  <= hit;
            idx_reg  <= CMP_W'(entry_index);
        end
    end

    // Point memory: one write port, one registered read port.
    assign rd_en   = cmd.scan_rd || cmd.idx_rd;
    assign rd_addr = cmd.scan_rd ? scan_addr_reg : idx_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.finish && cmd.store)
        begin
            pt_mem[count_reg[ADDR_W-1:0]] <= {x_reg, y_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= pt_mem[rd_addr];
        end
    end

    // Per-axis distance check against the entry read last cycle.
    assign sx  = rd_data_reg[ENTRY_W-1:COORD_BITS];
    assign sy  = rd_data_reg[COORD_BITS-1:0];
    assign dx  = (x_reg >= sx) ? (x_reg - sx) : (sx - x_reg);
    assign dy  = (y_reg >= sy) ? (y_reg - sy) : (sy - y_reg);
    assign rng = COORD_BITS'(range_min);
    assign near_now = rd_vld_reg && (dx < rng) && (dy < rng);

    // Scan address, read-valid pipeline bit and sticky near flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            near_reg      <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.scan_clr)
            begin
                scan_addr_reg <= '0;
                near_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_addr_reg <= ADDR_W'(scan_addr_reg + 1'b1);
                end
                if (near_now)
                begin
                    near_reg <= 1'b1;
                end
            end
        end
    end

    // Count and done flag after the finishing action.
    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (cmd.finish)
        begin
            if (cmd.clear)
            begin
                count_next = '0;
                done_next  = 1'b0;
            end
            if (cmd.store)
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
            if (cmd.set_done)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result register: valid is control, the payload loads on finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg   <= cmd.status;
            pcount_reg   <= pdc_pkg::COUNT_W'(count_next);
            finished_reg <= done_next;
            if (cmd.status == pdc_pkg::ST_READ_OK)
            begin
                read_x_reg <= pdc_pkg::POS_W'(sx);
                read_y_reg <= pdc_pkg::POS_W'(sy);
            end
            else
            begin
                read_x_reg <= '0;
                read_y_reg <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_point_count = pcount_reg;
    assign out_read_x      = read_x_reg;
    assign out_read_y      = read_y_reg;
    assign out_finished    = finished_reg;

    // Status toward the controller.
    always_comb
    begin
        st.func      = func_reg;
        st.hit       = hit_reg;
        st.done      = done_reg;
        st.full      = (count_reg >= CNT_W'(MAX_POINTS));
        st.empty     = (count_reg == '0);
        st.idx_ok    = (idx_reg < CMP_W'(count_reg));
        st.scan_last = (CNT_W'(CNT_W'(scan_addr_reg) + 1'b1) == count_reg);
        st.near      = near_reg || near_now;
        st.out_free  = !out_valid_reg || out_ready;
    end

endmodule

// File: design/point_dedup_collector.sv
// ============================================================================
// point_dedup_collector
// Collects matching scan points into a table, rejecting near duplicates; also serves entry reads and clears.
// ============================================================================
// One request beat is handled at a time. A matching candidate that has to be
// checked against N stored points is compared one entry per cycle through
// the single read port of the point memory; an entry read also passes
// through that registered port. The result sits in an output register, so
// the next request is taken as soon as the previous one has been issued
// there. The table needs no clearing pass after reset: entries beyond the
// point count are never read.
module point_dedup_collector
#(
    parameter int MAX_POINTS = pdc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    pdc_item_if.sink                            item_in,
    pdc_result_if.source                        result_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pdc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [pdc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [pdc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [pdc_pkg::RANGE_W-1:0] range_min_reg;
    logic                        exit_on_first_reg;
    logic                        cfg_wr;
    pdc_pkg::pdc_cmd_t           cmd;
    pdc_pkg::pdc_stat_t          st;

    // Configuration registers, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg     <= pdc_pkg::RANGE_MIN_RST;
            exit_on_first_reg <= pdc_pkg::EXIT_ON_FIRST_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                pdc_pkg::REG_RANGE_MIN:     range_min_reg     <= pwdata[pdc_pkg::RANGE_W-1:0];
                pdc_pkg::REG_EXIT_ON_FIRST: exit_on_first_reg <= pwdata[0];
                default:                    range_min_reg     <= range_min_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[2])
            pdc_pkg::REG_RANGE_MIN:     prdata = pdc_pkg::APB_DATA_W'(range_min_reg);
            pdc_pkg::REG_EXIT_ON_FIRST: prdata = pdc_pkg::APB_DATA_W'(exit_on_first_reg);
            default:                    prdata = '0;
        endcase
    end

    // Controller.
    pdc_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_in.valid),
        .item_ready    (item_in.ready),
        .exit_on_first (exit_on_first_reg),
        .st            (st),
        .cmd           (cmd)
    );

    // Datapath.
    pdc_dp
    #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .range_min       (range_min_reg),
        .cmd             (cmd),
        .st              (st),
        .func            (item_in.func),
        .pos_x           (item_in.pos_x),
        .pos_y           (item_in.pos_y),
        .hit             (item_in.hit),
        .entry_index     (item_in.entry_index),
        .out_valid       (result_out.valid),
        .out_ready       (result_out.ready),
        .out_status      (result_out.status),
        .out_point_count (result_out.point_count),
        .out_read_x      (result_out.read_x),
        .out_read_y      (result_out.read_y),
        .out_finished    (result_out.finished)
    );

endmodule

// File: design/pdc_checker.sv
// ============================================================================
// pdc_checker
// Port-level checks on the result channel of the point dedup collector.
// ============================================================================
module pdc_checker
#(
    parameter int MAX_POINTS = pdc_pkg::MAX_POINTS_DEF
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [pdc_pkg::STATUS_W-1:0]     status,
    input logic [pdc_pkg::COUNT_W-1:0]      point_count,
    input logic [pdc_pkg::POS_W-1:0]        read_x,
    input logic [pdc_pkg::POS_W-1:0]        read_y,
    input logic                             finished
);

    // A stalled result beat keeps its status, point count and finished flag.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(point_count) && $stable(finished))
        else $error("result beat changed while stalled");

    // A clear leaves an empty table and an open search.
    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pdc_pkg::ST_CLEARED |-> point_count == '0 && !finished)
        else $error("clear did not empty the table");

    // Only a successful read carries coordinates.
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pdc_pkg::ST_READ_OK |-> read_x == '0 && read_y == '0)
        else $error("read data on a result that is not a read");

    // A stored point leaves a nonempty table within its bound.
    a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pdc_pkg::ST_STORED |->
        point_count != '0 || MAX_POINTS >= 32)
        else $error("stored point with empty count");

endmodule

bind point_dedup_collector pdc_checker
#(
    .MAX_POINTS (MAX_POINTS)
)
u_pdc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .status      (result_out.status),
    .point_count (result_out.point_count),
    .read_x      (result_out.read_x),
    .read_y      (result_out.read_y),
    .finished    (result_out.finished)
);
